// File: hw/rtl/ikt_pkg.sv
// Shared sizes, clamp helpers and the control-to-datapath bundle of the keyer.
`default_nettype none

package ikt_pkg;

  localparam int TONE_DEPTH  = 1024;
  localparam int ENV_DEPTH   = 1024;
  localparam int QUEUE_DEPTH = 32;

  localparam int TONE_AW  = $clog2(TONE_DEPTH);
  localparam int ENV_AW   = $clog2(ENV_DEPTH);
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int PER_W    = TONE_AW + 1;
  localparam int RISE_W   = ENV_AW + 1;

  localparam int CNT_W     = 20;
  localparam int STEP_W    = $clog2(CNT_W);
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int DAH_UNITS   = 3;
  localparam int PAUSE_UNITS = 1;

  localparam int PERIOD_W = 11;
  localparam int DIT_W    = 16;
  localparam int RISE_CW  = 11;
  localparam int CFG_W    = 20;
  localparam int CFG_IW   = 3;
  localparam int SAMPLE_W = 16;
  localparam int QLVL_W   = 6;

  // Tone period in use: zero counts as one, capped at the table depth.
  function automatic logic [PER_W-1:0] per_clamp(input logic [PERIOD_W-1:0] p);
    logic [PER_W-1:0] r;
    if (p == '0) begin
      r = PER_W'(1);
    end else if (32'(p) > TONE_DEPTH) begin
      r = PER_W'(TONE_DEPTH);
    end else begin
      r = PER_W'(p);
    end
    return r;
  endfunction

  function automatic logic [RISE_W-1:0] rise_clamp(input logic [RISE_CW-1:0] p);
    logic [RISE_W-1:0] r;
    if (32'(p) > ENV_DEPTH) begin
      r = RISE_W'(ENV_DEPTH);
    end else begin
      r = RISE_W'(p);
    end
    return r;
  endfunction

  typedef struct packed {
    logic                tick;
    logic                zero;
    logic                shaped;
    logic [TONE_AW-1:0]  tone_addr;
    logic [ENV_AW-1:0]   env_addr;
    logic [1:0]          led;
    logic                key;
    logic [2:0]          mode;
    logic [QLVL_W-1:0]   qlvl;
    logic                tone_we;
    logic                env_we;
    logic [TONE_AW-1:0]  tone_waddr;
    logic [ENV_AW-1:0]   env_waddr;
    logic [SAMPLE_W-1:0] wval;
  } ikt_op_t;

endpackage

`default_nettype wire

// File: hw/rtl/iambic_morse_keyer_tone.sv
// Top level of the iambic keyer with tone synthesis.
`default_nettype none

// Iambic Morse keyer that produces one shaped audio sample for every sample-tick
// transaction (tuser 0); symbol pushes and table writes (tuser 1..3) give no result.
// One transaction is taken per clock unless the output stalls or a phase recompute
// holds the input off. A sample is registered first by the tone and envelope memory
// reads and then, after the shaping multiply, by the output register. After a
// tone_period write a bit-serial unit recomputes the tone phase from the position
// counter. The tone and envelope tables must be loaded before keying.
module iambic_morse_keyer_tone (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // dit_pressed, dah_pressed, symbol[1:0],
                                       // table_index[9:0], table_value[15:0]
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // sample[15:0], led_color[1:0], key_down,
                                       // keyer_mode[2:0], queue_level[5:0]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_wdata
);

  ikt_pkg::ikt_op_t op;
  logic             en;

  ikt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .en        (en),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .op        (op)
  );

  ikt_synth u_synth (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ikt_phase_div.sv
// Bit-serial remainder unit: recomputes the tone phase after a period change.
`default_nettype none

module ikt_phase_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ikt_pkg::CNT_W-1:0]   dividend,
  input  wire logic [ikt_pkg::PER_W-1:0]   divisor,
  output logic                             busy,
  output logic                             done,
  output logic [ikt_pkg::TONE_AW-1:0]      rem
);

  logic                          busy_r;
  logic                          done_r;
  logic [ikt_pkg::STEP_W-1:0]    step_r;
  logic [ikt_pkg::CNT_W-1:0]     dvd_r;
  logic [ikt_pkg::PER_W-1:0]     div_r;
  logic [ikt_pkg::TONE_AW-1:0]   rem_r;
  logic [ikt_pkg::PER_W-1:0]     trial;
  logic [ikt_pkg::TONE_AW-1:0]   rem_nxt;

  // remainder stays below the divisor, which never exceeds the table depth
  always_comb begin
    trial = {rem_r, dvd_r[ikt_pkg::CNT_W-1]};
    if (trial >= div_r) begin
      rem_nxt = ikt_pkg::TONE_AW'(trial - div_r);
    end else begin
      rem_nxt = ikt_pkg::TONE_AW'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= ikt_pkg::STEP_W'(ikt_pkg::CNT_W - 1);
        dvd_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[ikt_pkg::CNT_W-2:0], 1'b0};
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// File: hw/rtl/ikt_ctrl.sv
// Keyer sequencer: config registers, symbol queue memory, mode machine, position counters.
`default_nettype none

module ikt_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [31:0]                in_tdata,
  input  wire logic [1:0]                 in_tuser,
  input  wire logic                       en,
  input  wire logic                       cfg_we,
  input  wire logic [ikt_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [ikt_pkg::CFG_W-1:0]  cfg_wdata,
  output ikt_pkg::ikt_op_t                op
);

  typedef enum logic [2:0] {
    M_INIT      = 3'd0,
    M_INIT_WAIT = 3'd1,
    M_IDLE      = 3'd2,
    M_DIT       = 3'd3,
    M_DAH       = 3'd4,
    M_DIT_PAUSE = 3'd5,
    M_DAH_PAUSE = 3'd6
  } mode_t;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_PUSH = 2'd1;
  localparam logic [1:0] FUNC_TONE = 2'd2;
  localparam logic [1:0] FUNC_ENV  = 2'd3;

  localparam logic [1:0] SYM_PAUSE = 2'd0;
  localparam logic [1:0] SYM_DIT   = 2'd1;
  localparam logic [1:0] SYM_DAH   = 2'd2;
  localparam logic [1:0] PEND_NONE = 2'd0;

  localparam logic [1:0] LED_OFF    = 2'd0;
  localparam logic [1:0] LED_PADDLE = 2'd1;
  localparam logic [1:0] LED_QUEUE  = 2'd2;

  localparam logic [ikt_pkg::CFG_IW-1:0] REG_TONE_PERIOD = 3'd0;
  localparam logic [ikt_pkg::CFG_IW-1:0] REG_DIT_LENGTH  = 3'd1;
  localparam logic [ikt_pkg::CFG_IW-1:0] REG_RISE        = 3'd2;
  localparam logic [ikt_pkg::CFG_IW-1:0] REG_INIT_WAIT   = 3'd3;
  localparam logic [ikt_pkg::CFG_IW-1:0] REG_TONE_EN     = 3'd4;

  localparam int QSUM_W = ikt_pkg::QCNT_W + 1;

  // configuration
  logic [ikt_pkg::PERIOD_W-1:0] per_r;
  logic [ikt_pkg::DIT_W-1:0]    dit_r;
  logic [ikt_pkg::RISE_CW-1:0]  rise_r;
  logic [ikt_pkg::CNT_W-1:0]    wait_r;
  logic                         ten_r;

  // keyer state
  mode_t                        mode_r, mode_nxt;
  logic [1:0]                   pend_r, pend_nxt;
  logic [1:0]                   ind_r, ind_nxt;
  logic [ikt_pkg::CNT_W-1:0]    el_r, el_nxt;
  logic [ikt_pkg::CNT_W-1:0]    end_r, end_nxt;
  logic [ikt_pkg::TONE_AW-1:0]  ph_r, ph_nxt;
  logic [ikt_pkg::QUEUE_AW-1:0] head_r, head_nxt;
  logic [ikt_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         start_r;

  logic [1:0] qmem [QUEUE_DEPTH_C];
  logic [1:0] q_rd_r;

  localparam int QUEUE_DEPTH_C = ikt_pkg::QUEUE_DEPTH;

  logic [1:0]                   func;
  logic                         dit, dah;
  logic [1:0]                   sym;
  logic [9:0]                   idx;
  logic                         acc, tick, push_ok;
  logic [ikt_pkg::PER_W-1:0]    per_c;
  logic [ikt_pkg::RISE_W-1:0]   rise_c;
  logic [ikt_pkg::CNT_W-1:0]    dit_end, dah_end;
  logic                         el_hit;
  logic [ikt_pkg::QUEUE_AW-1:0] head_inc, q_waddr;
  logic [QSUM_W-1:0]            q_sum;
  logic                         restart, do_begin;
  logic [1:0]                   bsym, bcol;
  logic [ikt_pkg::CNT_W-1:0]    pos;
  logic [ikt_pkg::TONE_AW-1:0]  ph_cur;
  logic [ikt_pkg::PER_W-1:0]    ph_inc;
  logic                         key, rise_lo, rise_hi;
  logic                         div_busy, div_done;
  logic [ikt_pkg::TONE_AW-1:0]  div_rem;

  assign func = in_tuser;
  assign dit  = in_tdata[0];
  assign dah  = in_tdata[1];
  assign sym  = in_tdata[3:2];
  assign idx  = in_tdata[13:4];

  // hold off while the phase is being recomputed after a period write
  assign in_tready = en && !start_r && !div_busy && !div_done;
  assign acc       = in_tvalid && in_tready;
  assign tick      = acc && (func == FUNC_TICK);
  assign push_ok   = acc && (func == FUNC_PUSH) && (sym != 2'd3) &&
                     (cnt_r < ikt_pkg::QCNT_W'(ikt_pkg::QUEUE_DEPTH));

  assign per_c   = ikt_pkg::per_clamp(per_r);
  assign rise_c  = ikt_pkg::rise_clamp(rise_r);
  assign dit_end = ikt_pkg::CNT_W'(32'(dit_r) * ikt_pkg::PAUSE_UNITS);
  assign dah_end = ikt_pkg::CNT_W'(32'(dit_r) * ikt_pkg::DAH_UNITS);
  assign el_hit  = (el_r > end_r) || (el_r == ikt_pkg::CNT_MAX);

  assign head_inc = (head_r == ikt_pkg::QUEUE_AW'(ikt_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : head_r + 1'b1;
  assign q_sum    = QSUM_W'(head_r) + QSUM_W'(cnt_r);
  assign q_waddr  = ikt_pkg::QUEUE_AW'((q_sum >= QSUM_W'(ikt_pkg::QUEUE_DEPTH)) ?
                    q_sum - QSUM_W'(ikt_pkg::QUEUE_DEPTH) : q_sum);

  ikt_phase_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (el_r),
    .divisor  (per_c),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    ind_nxt  = ind_r;
    end_nxt  = end_r;
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    el_nxt   = el_r;
    ph_nxt   = ph_r;
    restart  = 1'b0;
    do_begin = 1'b0;
    bsym     = SYM_DIT;
    bcol     = LED_OFF;
    pos      = el_r;
    ph_cur   = ph_r;
    ph_inc   = '0;
    if (tick) begin
      case (mode_r)
        M_INIT: begin
          restart  = 1'b1;
          end_nxt  = ikt_pkg::CNT_W'(wait_r);
          mode_nxt = M_INIT_WAIT;
        end
        M_IDLE: begin
          restart  = 1'b1;
          do_begin = 1'b1;
          bcol     = LED_PADDLE;
          cnt_nxt  = '0;
          if (pend_r == SYM_DIT) begin
            bsym = SYM_DIT;
          end else if (pend_r == SYM_DAH) begin
            bsym = SYM_DAH;
          end else if (dit) begin
            bsym = SYM_DIT;
          end else if (dah) begin
            bsym = SYM_DAH;
          end else if (cnt_r != '0) begin
            bsym     = q_rd_r;
            bcol     = LED_QUEUE;
            cnt_nxt  = cnt_r - 1'b1;
            head_nxt = head_inc;
          end else begin
            do_begin = 1'b0;
            cnt_nxt  = cnt_r;
            ind_nxt  = LED_OFF;
          end
        end
        default: begin
          if (el_hit) begin
            restart = 1'b1;
            case (mode_r)
              M_DIT, M_DAH: begin
                do_begin = 1'b1;
                bsym     = SYM_PAUSE;
                bcol     = LED_OFF;
              end
              M_DIT_PAUSE: begin
                if (dah) begin
                  do_begin = 1'b1;
                  bsym     = SYM_DAH;
                  bcol     = LED_PADDLE;
                end else begin
                  mode_nxt = M_IDLE;
                end
              end
              M_DAH_PAUSE: begin
                if (dit) begin
                  do_begin = 1'b1;
                  bsym     = SYM_DIT;
                  bcol     = LED_PADDLE;
                end else begin
                  mode_nxt = M_IDLE;
                end
              end
              default: mode_nxt = M_IDLE;
            endcase
          end else if (mode_r == M_DIT_PAUSE && dah) begin
            pend_nxt = SYM_DAH;
          end else if (mode_r == M_DAH_PAUSE && dit) begin
            pend_nxt = SYM_DIT;
          end
        end
      endcase

      if (do_begin) begin
        ind_nxt = bcol;
        case (bsym)
          SYM_PAUSE: begin
            pend_nxt = PEND_NONE;
            end_nxt  = dit_end;
            mode_nxt = (mode_r == M_DIT) ? M_DIT_PAUSE : M_DAH_PAUSE;
          end
          SYM_DIT: begin
            end_nxt  = dit_end;
            mode_nxt = M_DIT;
          end
          default: begin
            end_nxt  = dah_end;
            mode_nxt = M_DAH;
          end
        endcase
      end
      if (mode_r == M_IDLE) begin
        pend_nxt = PEND_NONE;
      end

      if (restart) begin
        pos    = '0;
        ph_cur = '0;
      end
      // phase tracks pos modulo the period; both hold once pos saturates
      ph_inc = ikt_pkg::PER_W'(ph_cur) + 1'b1;
      if (pos != ikt_pkg::CNT_MAX) begin
        el_nxt = pos + 1'b1;
        ph_nxt = (ph_inc == per_c) ? '0 : ikt_pkg::TONE_AW'(ph_inc);
      end else begin
        el_nxt = pos;
        ph_nxt = ph_cur;
      end
    end
    if (push_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (div_done) begin
      ph_nxt = div_rem;
    end
  end

  assign key     = (mode_nxt == M_DIT) || (mode_nxt == M_DAH);
  assign rise_lo = pos < ikt_pkg::CNT_W'(rise_c);
  assign rise_hi = ({1'b0, pos} + (ikt_pkg::CNT_W + 1)'(rise_c)) > {1'b0, end_nxt};

  always_comb begin
    op            = '0;
    op.tick       = tick;
    op.zero       = !(key && ten_r) || (pos >= end_nxt);
    op.shaped     = rise_lo || rise_hi;
    op.tone_addr  = ph_cur;
    op.env_addr   = rise_lo ? ikt_pkg::ENV_AW'(pos) : ikt_pkg::ENV_AW'(end_nxt - pos);
    op.led        = ind_nxt;
    op.key        = key;
    op.mode       = mode_nxt;
    op.qlvl       = ikt_pkg::QLVL_W'(cnt_nxt);
    op.tone_we    = acc && (func == FUNC_TONE) && (32'(idx) < ikt_pkg::TONE_DEPTH);
    op.env_we     = acc && (func == FUNC_ENV) && (32'(idx) < ikt_pkg::ENV_DEPTH);
    op.tone_waddr = ikt_pkg::TONE_AW'(idx);
    op.env_waddr  = ikt_pkg::ENV_AW'(idx);
    op.wval       = in_tdata[29:14];
  end

  // queue memory with the head entry prefetched; a push into the head is forwarded
  always_ff @(posedge clk) begin
    if (push_ok) begin
      qmem[q_waddr] <= sym;
    end
    if (push_ok && (q_waddr == head_nxt)) begin
      q_rd_r <= sym;
    end else begin
      q_rd_r <= qmem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_r   <= ikt_pkg::PERIOD_W'(69);
      dit_r   <= ikt_pkg::DIT_W'(2898);
      rise_r  <= ikt_pkg::RISE_CW'(289);
      wait_r  <= ikt_pkg::CNT_W'(48000);
      ten_r   <= 1'b1;
      mode_r  <= M_INIT;
      pend_r  <= PEND_NONE;
      ind_r   <= LED_OFF;
      el_r    <= '0;
      end_r   <= '0;
      ph_r    <= '0;
      head_r  <= '0;
      cnt_r   <= '0;
      start_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      ind_r   <= ind_nxt;
      el_r    <= el_nxt;
      end_r   <= end_nxt;
      ph_r    <= ph_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      start_r <= cfg_we && (cfg_index == REG_TONE_PERIOD);
      if (cfg_we) begin
        case (cfg_index)
          REG_TONE_PERIOD: per_r  <= cfg_wdata[ikt_pkg::PERIOD_W-1:0];
          REG_DIT_LENGTH:  dit_r  <= cfg_wdata[ikt_pkg::DIT_W-1:0];
          REG_RISE:        rise_r <= cfg_wdata[ikt_pkg::RISE_CW-1:0];
          REG_INIT_WAIT:   wait_r <= cfg_wdata[ikt_pkg::CNT_W-1:0];
          REG_TONE_EN:     ten_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ikt_pkg::QCNT_W'(ikt_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_phase_in_period: assert property (@(posedge clk) disable iff (!rst_n)
    tick |-> (ikt_pkg::PER_W'(ph_r) < per_c))
    else $error("tone phase outside period at tick");

  a_init_step: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && mode_r == M_INIT) |=> (mode_r == M_INIT_WAIT && el_r == ikt_pkg::CNT_W'(1)))
    else $error("first tick did not enter init wait");

  a_div_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (start_r || div_busy || div_done) |-> !in_tready)
    else $error("input taken during phase recompute");

endmodule

`default_nettype wire

// File: hw/rtl/ikt_synth.sv
// Tone and envelope tables, shaping multiply and the output register stage.
`default_nettype none

module ikt_synth (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ikt_pkg::ikt_op_t op,
  output logic                  en,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [31:0]           out_tdata
);

  localparam int TONE_D = ikt_pkg::TONE_DEPTH;
  localparam int ENV_D  = ikt_pkg::ENV_DEPTH;

  logic [ikt_pkg::SAMPLE_W-1:0] tone_mem [TONE_D];
  logic [ikt_pkg::SAMPLE_W-1:0] env_mem  [ENV_D];

  logic [ikt_pkg::SAMPLE_W-1:0] tone_rd_r, env_rd_r;
  logic                         s1_valid_r, s1_zero_r, s1_shaped_r, s1_key_r;
  logic [1:0]                   s1_led_r;
  logic [2:0]                   s1_mode_r;
  logic [ikt_pkg::QLVL_W-1:0]   s1_qlvl_r;

  logic                         out_valid_r, key_r;
  logic [ikt_pkg::SAMPLE_W-1:0] sample_r;
  logic [1:0]                   led_r;
  logic [2:0]                   mode_r;
  logic [ikt_pkg::QLVL_W-1:0]   qlvl_r;

  logic                         neg;
  logic [ikt_pkg::SAMPLE_W-1:0] mag, scaled, shaped_v, sample_c;
  logic [2*ikt_pkg::SAMPLE_W-1:0] prod;

  assign en = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (op.tone_we) begin
      tone_mem[op.tone_waddr] <= op.wval;
    end
    if (op.env_we) begin
      env_mem[op.env_waddr] <= op.wval;
    end
    if (en) begin
      tone_rd_r   <= tone_mem[op.tone_addr];
      env_rd_r    <= env_mem[op.env_addr];
      s1_zero_r   <= op.zero;
      s1_shaped_r <= op.shaped;
      s1_key_r    <= op.key;
      s1_led_r    <= op.led;
      s1_mode_r   <= op.mode;
      s1_qlvl_r   <= op.qlvl;
    end
  end

  // sign-magnitude multiply so the shift truncates toward zero
  always_comb begin
    neg    = tone_rd_r[ikt_pkg::SAMPLE_W-1];
    mag    = neg ? (~tone_rd_r + 1'b1) : tone_rd_r;
    prod   = mag * env_rd_r;
    scaled = prod[2*ikt_pkg::SAMPLE_W-1:ikt_pkg::SAMPLE_W];
    shaped_v = neg ? (~scaled + 1'b1) : scaled;
    if (s1_zero_r) begin
      sample_c = '0;
    end else if (s1_shaped_r) begin
      sample_c = shaped_v;
    end else begin
      sample_c = tone_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_r <= sample_c;
      led_r    <= s1_led_r;
      key_r    <= s1_key_r;
      mode_r   <= s1_mode_r;
      qlvl_r   <= s1_qlvl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= op.tick;
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, qlvl_r, mode_r, key_r, led_r, sample_r};

endmodule

`default_nettype wire
